>>> hw/rtl/cpf_pkg.sv
`timescale 1ns / 1ps

package cpf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_TOP  = 16'h8000;
    localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'd128;

    // Position of a byte within the run of up to four wire bytes one item makes
    typedef enum logic [1:0] {
        POS_ADDR   = 2'd0,
        POS_DATA   = 2'd1,
        POS_CRC_HI = 2'd2,
        POS_CRC_LO = 2'd3
    } cpf_pos_t;

    // One accepted item, ready for serialization
    typedef struct packed {
        logic              with_addr;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CRC_W-1:0]  crc;
    } cpf_item_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [CRC_W-1:0] cpf_crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if ((c & CRC_TOP) != '0)
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [CRC_W-1:0] ADDR_CRC_RESET = cpf_crc_byte('0, DEVICE_ADDRESS_RESET);

endpackage

>>> hw/rtl/cpf_if.sv
`timescale 1ns / 1ps

interface cpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_last;

    modport source (output valid, output in_byte, output frame_last, input ready);
    modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

interface cpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    output ready);
endinterface

>>> hw/rtl/cpf_serializer.sv
`timescale 1ns / 1ps

module cpf_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cpf_pkg::cpf_item_t load_item,
    output logic               load_ready,
    cpf_out_if.source          out_ch
);
    import cpf_pkg::*;

    cpf_item_t         item_reg;
    logic              item_valid_reg;
    cpf_pos_t          pos_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              frame_end_reg;

    cpf_pos_t          final_pos;
    logic              out_free;
    logic              move;
    logic              item_done;
    logic [BYTE_W-1:0] sel_byte;

    assign final_pos  = item_reg.last ? POS_CRC_LO : POS_DATA;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign move       = item_valid_reg && out_free;
    assign item_done  = move && (pos_reg == final_pos);
    assign load_ready = !item_valid_reg || item_done;

    always_comb
    begin
        case (pos_reg)
            POS_ADDR:   sel_byte = item_reg.addr;
            POS_DATA:   sel_byte = item_reg.data;
            POS_CRC_HI: sel_byte = item_reg.crc[CRC_W-1:BYTE_W];
            POS_CRC_LO: sel_byte = item_reg.crc[BYTE_W-1:0];
            default:    sel_byte = item_reg.data;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            pos_reg        <= POS_ADDR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                item_valid_reg <= 1'b1;
                pos_reg        <= load_item.with_addr ? POS_ADDR : POS_DATA;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            else if (move)
            begin
                pos_reg <= cpf_pos_t'(pos_reg + 2'd1);
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
        if (move)
        begin
            out_byte_reg  <= sel_byte;
            run_last_reg  <= (pos_reg == final_pos);
            frame_end_reg <= (pos_reg == POS_CRC_LO);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.run_last  = run_last_reg;
    assign out_ch.frame_end = frame_end_reg;

endmodule

>>> hw/rtl/crc16_command_packet_framer_unit.sv
`timescale 1ns / 1ps
// An input byte is held in the item register; each wire byte goes out via the output register.
// Throughput: one output byte per cycle while the receiver is ready; an item makes 1 to 4
//   wire bytes (address + command on packet start, the payload byte, two CRC bytes at the end).
// Reset (rst_n, async, active low): device address back to 128, CRC and packet state
//   cleared, no item held, output valid low.

module crc16_command_packet_framer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    cpf_in_if.sink            in_ch,
    cpf_out_if.source         out_ch
);
    import cpf_pkg::*;

    // Device address register plus the CRC of the address alone. The latter is
    // the CRC seed for the command byte, so each item needs a single byte update.
    logic [BYTE_W-1:0] addr_reg;
    logic [CRC_W-1:0]  addr_crc_reg;

    // Running CRC over the open packet, and whether a packet is open
    logic [CRC_W-1:0]  crc_reg;
    logic              inside_reg;

    logic [CRC_W-1:0]  crc_base;
    logic [CRC_W-1:0]  crc_next;
    logic              accept;
    logic              load_ready;
    cpf_item_t         item;

    assign in_ch.ready = load_ready;
    assign accept      = in_ch.valid && load_ready;

    // Command byte starts from the address CRC; payload continues the running CRC
    assign crc_base = inside_reg ? crc_reg : addr_crc_reg;
    assign crc_next = cpf_crc_byte(crc_base, in_ch.in_byte);

    always_comb
    begin
        item.with_addr = !inside_reg;
        item.addr      = addr_reg;
        item.data      = in_ch.in_byte;
        item.last      = in_ch.frame_last;
        item.crc       = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= DEVICE_ADDRESS_RESET;
            addr_crc_reg <= ADDR_CRC_RESET;
            crc_reg      <= '0;
            inside_reg   <= 1'b0;
        end
        else
        begin
            // user changes config only while idle (unenforced); address is sampled per command byte
            if (cfg_we)
            begin
                addr_reg     <= cfg_wdata;
                addr_crc_reg <= cpf_crc_byte('0, cfg_wdata);
            end
            if (accept)
            begin
                crc_reg    <= crc_next;
                inside_reg <= !in_ch.frame_last;
            end
        end
    end

    // Item register + output register; emits the wire bytes one per cycle while the receiver is ready
    cpf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_item  (item),
        .load_ready (load_ready),
        .out_ch     (out_ch)
    );

endmodule

>>> hw/rtl/cpf_checker.sv
`timescale 1ns / 1ps

module cpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       frame_end
);
    // items accepted whose last byte has not yet left
    logic [2:0] open_reg;
    logic       in_acc;
    logic       out_done;

    assign in_acc   = in_valid && in_ready;
    assign out_done = out_valid && out_ready && run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + {2'b00, in_acc} - {2'b00, out_done};
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(frame_end))
        else $error("output changed while stalled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("packet end not on last byte of item");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 3'd2)
        else $error("more than two items in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == 3'd0 |-> !out_valid)
        else $error("output without an accepted item");

endmodule

bind crc16_command_packet_framer_unit cpf_checker u_cpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last),
    .frame_end (out_ch.frame_end)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cpf_pkg::*;

    // One byte on the wire as the framer should emit it
    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              frame_end;
    } wire_byte_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [BYTE_W-1:0] cfg_wdata;

    cpf_in_if  in_ch();
    cpf_out_if out_ch();

    crc16_command_packet_framer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Shadow of the framer: address register, running CRC, packet state
    logic [BYTE_W-1:0] addr_shadow;
    logic [CRC_W-1:0]  crc_shadow;
    logic              in_packet;

    // Wire bytes predicted but not yet seen on out_ch, oldest first
    wire_byte_t wire_bytes_due[$];

    // Flow-control knobs, percent of cycles spent idle / stalled
    int unsigned src_idle_pct;
    int unsigned rcv_stall_pct;

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned bytes_checked;
    int unsigned packets_framed;
    int unsigned addr_writes;

    // XMODEM CRC, one byte, MSB first: feedback is top CRC bit xor next data bit
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic fb;
        r = crc;
        for (int k = BYTE_W - 1; k >= 0; k--)
        begin
            fb = r[CRC_W-1] ^ b[k];
            r = {r[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Wire bytes caused by one accepted input transaction.
    // The address is taken from the shadow only on a command byte, so a
    // register write inside a packet shows up at the next packet.
    task automatic predict_wire_bytes(input logic [BYTE_W-1:0] b, input logic lst);
        if (!in_packet)
        begin
            crc_shadow = crc16_step('0, addr_shadow);
            wire_bytes_due.push_back('{out_byte: addr_shadow, run_last: 1'b0,
                                       frame_end: 1'b0});
        end
        crc_shadow = crc16_step(crc_shadow, b);
        wire_bytes_due.push_back('{out_byte: b, run_last: !lst, frame_end: 1'b0});
        if (lst)
        begin
            wire_bytes_due.push_back('{out_byte: crc_shadow[15:8], run_last: 1'b0,
                                       frame_end: 1'b0});
            wire_bytes_due.push_back('{out_byte: crc_shadow[7:0], run_last: 1'b1,
                                       frame_end: 1'b1});
            in_packet = 1'b0;
            packets_framed++;
        end
        else
        begin
            in_packet = 1'b1;
        end
    endtask

    // Sender: called at a falling edge, returns at the falling edge after the
    // transaction. valid stays high on return so back-to-back bytes never see
    // a low/high pair in one time step.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.frame_last <= lst;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predict_wire_bytes(b, lst);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait until every predicted byte has come out, then add a margin.
    task automatic drain;
        in_ch.valid <= 1'b0;
        while (wire_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Register write; only called with the block drained
    task automatic set_device_address(input logic [BYTE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        addr_shadow = v;
        addr_writes++;
    endtask

    // Receiver: ready decided at the falling edge
    always @(negedge clk)
    begin
        out_ch.ready <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
    end

    // Checker: every output transaction against the oldest prediction
    always @(posedge clk)
    begin
        wire_byte_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            bytes_checked++;
            if (wire_bytes_due.size() == 0)
            begin
                $error("unexpected output byte %02h, nothing predicted", out_ch.out_byte);
                mismatch_count++;
            end
            else
            begin
                want = wire_bytes_due.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                begin
                    $error("out_byte expected %02h actual %02h", want.out_byte,
                           out_ch.out_byte);
                    mismatch_count++;
                end
                if (out_ch.run_last !== want.run_last)
                begin
                    $error("run_last expected %0b actual %0b", want.run_last,
                           out_ch.run_last);
                    mismatch_count++;
                end
                if (out_ch.frame_end !== want.frame_end)
                begin
                    $error("frame_end expected %0b actual %0b", want.frame_end,
                           out_ch.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Address after reset must be 128; single-byte packet gives all four bytes
    task automatic test_default_address;
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b1);
        drain();
    endtask

    // Field extremes and both address extremes, short and longer packets
    task automatic test_extremes;
        set_device_address(8'h00);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        drain();
        set_device_address(8'hFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();
    endtask

    // Register write between command and payload: current packet keeps the
    // old address and CRC, the next packet picks up the new address
    task automatic test_address_mid_packet;
        set_device_address(8'h3C);
        send_byte(8'h11, 1'b0);
        drain();
        set_device_address(8'hC3);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h44, 1'b1);
        drain();
    endtask

    // Mostly well-formed packets with random content; the rest is noise,
    // lone bytes with a random last flag. Occasional address rewrites
    // between packets.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned n_items,
                                       input logic [BYTE_W-1:0] start_addr);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        src_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
        set_device_address(start_addr);
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
                for (int unsigned i = 0; i < len; i++)
                begin
                    send_byte(BYTE_W'($urandom_range(255)), i == len - 1);
                end
                sent += len;
            end
            else
            begin
                send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                sent++;
            end
            if (!in_packet && $urandom_range(15) == 0)
            begin
                drain();
                set_device_address(BYTE_W'($urandom_range(255)));
            end
        end
        // close any open packet so the phase ends on a boundary
        if (in_packet)
        begin
            send_byte(BYTE_W'($urandom_range(255)), 1'b1);
        end
        drain();
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = '0;
        in_ch.frame_last = 1'b0;
        out_ch.ready     = 1'b0;
        src_idle_pct     = 0;
        rcv_stall_pct    = 0;
        mismatch_count   = 0;
        items_sent       = 0;
        bytes_checked    = 0;
        packets_framed   = 0;
        addr_writes      = 0;
        addr_shadow      = DEVICE_ADDRESS_RESET;
        crc_shadow       = '0;
        in_packet        = 1'b0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_address();
        test_extremes();
        test_address_mid_packet();

        // flow-control phases: none, sender sparse, receiver stalling, both
        test_random_traffic(0, 0, 88, BYTE_W'($urandom_range(255)));
        test_random_traffic(86, 0, 88, 8'hFF);
        test_random_traffic(0, 86, 88, 8'h00);
        test_random_traffic(27, 27, 88, BYTE_W'($urandom_range(255)));

        repeat (10) @(negedge clk);
        if (wire_bytes_due.size() != 0)
        begin
            $error("%0d predicted bytes never came out", wire_bytes_due.size());
            mismatch_count++;
        end

        $display("Sent %0d input transactions in %0d packets, checked %0d wire bytes,",
                 items_sent, packets_framed, bytes_checked);
        $display("with %0d address writes over four flow-control phases.", addr_writes);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
